[design/mxt_pkg.sv]
package mxt_pkg;

  // Value width and trie sizing
  localparam int VALUE_BITS = 16;
  localparam int CAPACITY   = 256;
  localparam int NODE_DEPTH = CAPACITY * VALUE_BITS + 1;

  localparam int NODE_W = $clog2(NODE_DEPTH);
  localparam int LVL_W  = $clog2(VALUE_BITS + 1);
  localparam int ITEM_W = $clog2(CAPACITY + 1);
  localparam int WORD_W = 2 * NODE_W;

  // Configuration port
  localparam int BC_W    = 5;
  localparam int BC_RST  = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam logic REG_BIT_COUNT = 1'b0;

  // Result handed from the trie engine to the output stage
  typedef struct packed {
    logic [VALUE_BITS-1:0] best_xor;
    logic [VALUE_BITS-1:0] running_max;
    logic                  full;
  } res_t;

endpackage

[design/mxt_ram.sv]
module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mxt_cfg.sv]
module mxt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mxt_pkg::ADDR_W-1:0]       paddr,
  input  logic [mxt_pkg::DATA_W-1:0]       pwdata,
  output logic [mxt_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output logic [mxt_pkg::LVL_W-1:0]        eff_bits
);

  logic [mxt_pkg::BC_W-1:0] bit_count;
  logic                     sel_bc;

  assign pready = 1'b1;
  assign sel_bc = (paddr[2] == mxt_pkg::REG_BIT_COUNT);

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= mxt_pkg::BC_W'(mxt_pkg::BC_RST);
    end else if (psel && penable && pwrite && pready && sel_bc) begin
      bit_count <= pwdata[mxt_pkg::BC_W-1:0];
    end
  end

  // Read back
  assign prdata = sel_bc ? {(mxt_pkg::DATA_W - mxt_pkg::BC_W)'(0), bit_count}
                         : '0;

  // Clamp the level count into one to the value width
  always_comb begin
    if (bit_count == '0) begin
      eff_bits = mxt_pkg::LVL_W'(1);
    end else if (int'(bit_count) > mxt_pkg::VALUE_BITS) begin
      eff_bits = mxt_pkg::LVL_W'(mxt_pkg::VALUE_BITS);
    end else begin
      eff_bits = mxt_pkg::LVL_W'(bit_count);
    end
  end

endmodule

[design/mxt_walk.sv]
module mxt_walk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mxt_pkg::VALUE_BITS-1:0]    number,
  input  logic [mxt_pkg::LVL_W-1:0]         eff_bits,
  output logic                              res_valid,
  input  logic                              res_take,
  output mxt_pkg::res_t                     res
);

  localparam int N  = mxt_pkg::NODE_W;
  localparam int VB = mxt_pkg::VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COUNT, ST_DECIDE, ST_LINK, ST_INS_NODE, ST_QSETUP, ST_QUERY, ST_FINISH
  } state_t;

  state_t                        state;
  logic [VB-1:0]                 num_al;
  logic [VB-1:0]                 nsh;
  logic [mxt_pkg::LVL_W-1:0]     lvl;
  logic [mxt_pkg::LVL_W-1:0]     bc;
  logic [mxt_pkg::LVL_W-1:0]     missing;
  logic                          cur_root;
  logic [N-1:0]                  div_node;
  logic                          div_root;
  logic [mxt_pkg::WORD_W-1:0]    div_word;
  logic [mxt_pkg::WORD_W-1:0]    root_word;
  logic                          full_flag;
  logic                          dead;
  logic [N-1:0]                  nodes_used;
  logic [mxt_pkg::ITEM_W-1:0]    items_stored;
  logic [VB-1:0]                 best;
  logic [VB-1:0]                 x;

  logic [mxt_pkg::WORD_W-1:0]    rdata;
  logic [mxt_pkg::WORD_W-1:0]    cur_word;
  logic                          bit_b;
  logic [N-1:0]                  c_same;
  logic [N-1:0]                  c_opp;
  logic [N-1:0]                  nu_inc;
  logic [mxt_pkg::WORD_W-1:0]    link_word;
  logic [mxt_pkg::WORD_W-1:0]    new_word;
  logic                          we;
  logic [N-1:0]                  waddr;
  logic [mxt_pkg::WORD_W-1:0]    wdata;
  logic [N-1:0]                  raddr;
  logic                          full_cond;
  logic [VB-1:0]                 best_next;

  // Child pointers of the node under the walk: root lives in flops
  assign cur_word = cur_root ? root_word : rdata;
  assign bit_b    = nsh[VB-1];
  assign c_same   = bit_b ? cur_word[2*N-1:N] : cur_word[N-1:0];
  assign c_opp    = bit_b ? cur_word[N-1:0]   : cur_word[2*N-1:N];
  assign nu_inc   = nodes_used + N'(1);

  // Read the next node on the path
  assign raddr = (state == ST_QUERY && c_opp != '0) ? c_opp : c_same;

  // Hook the new chain onto the last existing node, then lay the chain down
  assign link_word = bit_b ? {nodes_used, div_word[N-1:0]}
                           : {div_word[2*N-1:N], nodes_used};
  always_comb begin
    new_word = '0;
    if (missing > mxt_pkg::LVL_W'(1)) begin
      new_word = bit_b ? {nu_inc, N'(0)} : {N'(0), nu_inc};
    end
  end

  assign we    = (state == ST_LINK && !div_root) || (state == ST_INS_NODE);
  assign waddr = (state == ST_LINK) ? div_node : nodes_used;
  assign wdata = (state == ST_LINK) ? link_word : new_word;

  assign full_cond = (items_stored >= mxt_pkg::ITEM_W'(mxt_pkg::CAPACITY)) ||
                     (({1'b0, nodes_used} + (N+1)'(missing)) >
                      (N+1)'(mxt_pkg::NODE_DEPTH));

  assign best_next = (x > best) ? x : best;

  assign in_stall        = (state != ST_IDLE);
  assign res_valid       = (state == ST_FINISH);
  assign res.best_xor    = x;
  assign res.running_max = best_next;
  assign res.full        = full_flag;

  mxt_ram #(
    .WIDTH (mxt_pkg::WORD_W),
    .DEPTH (mxt_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer: count walk, insert, query walk, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      nodes_used   <= N'(1);
      items_stored <= '0;
      best         <= '0;
      root_word    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            num_al    <= number << (mxt_pkg::LVL_W'(VB) - eff_bits);
            nsh       <= number << (mxt_pkg::LVL_W'(VB) - eff_bits);
            bc        <= eff_bits;
            lvl       <= eff_bits;
            cur_root  <= 1'b1;
            div_node  <= '0;
            full_flag <= 1'b0;
            state     <= ST_COUNT;
          end
        end

        // Follow existing nodes until the path runs out
        ST_COUNT: begin
          if (c_same == '0) begin
            missing  <= lvl;
            div_root <= cur_root;
            div_word <= cur_word;
            state    <= ST_DECIDE;
          end else if (lvl == mxt_pkg::LVL_W'(1)) begin
            missing <= '0;
            state   <= ST_DECIDE;
          end else begin
            div_node <= c_same;
            cur_root <= 1'b0;
            nsh      <= nsh << 1;
            lvl      <= lvl - mxt_pkg::LVL_W'(1);
          end
        end

        ST_DECIDE: begin
          if (full_cond) begin
            full_flag <= 1'b1;
            state     <= ST_QSETUP;
          end else begin
            items_stored <= items_stored + mxt_pkg::ITEM_W'(1);
            state        <= (missing != '0) ? ST_LINK : ST_QSETUP;
          end
        end

        ST_LINK: begin
          if (div_root) begin
            root_word <= link_word;
          end
          nsh   <= nsh << 1;
          state <= ST_INS_NODE;
        end

        // One new node per cycle
        ST_INS_NODE: begin
          nodes_used <= nu_inc;
          nsh        <= nsh << 1;
          missing    <= missing - mxt_pkg::LVL_W'(1);
          if (missing == mxt_pkg::LVL_W'(1)) begin
            state <= ST_QSETUP;
          end
        end

        ST_QSETUP: begin
          nsh      <= num_al;
          lvl      <= bc;
          cur_root <= 1'b1;
          x        <= '0;
          dead     <= 1'b0;
          state    <= ST_QUERY;
        end

        // Take the opposite child where there is one, one result bit a cycle
        ST_QUERY: begin
          if (dead) begin
            x <= {x[VB-2:0], 1'b0};
          end else if (c_opp != '0) begin
            x        <= {x[VB-2:0], 1'b1};
            cur_root <= 1'b0;
          end else if (c_same != '0) begin
            x        <= {x[VB-2:0], 1'b0};
            cur_root <= 1'b0;
          end else begin
            x    <= {x[VB-2:0], 1'b0};
            dead <= 1'b1;
          end
          nsh <= nsh << 1;
          lvl <= lvl - mxt_pkg::LVL_W'(1);
          if (lvl == mxt_pkg::LVL_W'(1)) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (res_take) begin
            best  <= best_next;
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= N'(mxt_pkg::NODE_DEPTH))
    else $error("node count beyond store depth");

  a_items_bound: assert property (@(posedge clk) disable iff (rst)
    items_stored <= mxt_pkg::ITEM_W'(mxt_pkg::CAPACITY))
    else $error("item count beyond capacity");

  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0) && (waddr < N'(mxt_pkg::NODE_DEPTH)))
    else $error("node write outside the store");

  a_full_no_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && full_cond) |=>
      (nodes_used == $past(nodes_used)) && (items_stored == $past(items_stored)))
    else $error("insert done while full");

  a_best_rises: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_take) |=> best >= $past(best))
    else $error("running maximum fell");

endmodule

[design/max_xor_binary_trie_core.sv]
// The core takes one item at a time: in_stall stays high from accept until the
// result is taken, so a new item waits for the last one. Each item runs a count
// walk, an insert of any missing nodes (skipped when full) and a query walk, one
// trie level per cycle on the registered node read, before the result is handed
// to the output register.
// Reset (rst, synchronous): empty trie, running maximum zero, bit_count 16.
module max_xor_binary_trie_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     best_xor,
  output logic [15:0]                     running_max,
  output logic                            full_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mxt_pkg::ADDR_W-1:0]      paddr,
  input  logic [mxt_pkg::DATA_W-1:0]      pwdata,
  output logic [mxt_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  logic [mxt_pkg::LVL_W-1:0] eff_bits;
  logic                      res_valid;
  logic                      res_take;
  mxt_pkg::res_t             res;

  mxt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .eff_bits (eff_bits)
  );

  mxt_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .eff_bits  (eff_bits),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: take a new result when empty or draining
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      best_xor    <= res.best_xor;
      running_max <= res.running_max;
      full_res    <= res.full;
    end
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 195;
  localparam logic [mxt_pkg::ADDR_W-1:0] BIT_COUNT_ADDR =
    mxt_pkg::ADDR_W'(4 * mxt_pkg::REG_BIT_COUNT);

  // One directed item: bit_count to apply, number, and an optional fixed result
  typedef struct packed {
    logic [mxt_pkg::BC_W-1:0]       cfg;
    logic [mxt_pkg::VALUE_BITS-1:0] num;
    logic                           typed;
    mxt_pkg::res_t                  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] best_xor;
  logic [15:0] running_max;
  logic full_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mxt_pkg::ADDR_W-1:0] paddr = '0;
  logic [mxt_pkg::DATA_W-1:0] pwdata = '0;
  logic [mxt_pkg::DATA_W-1:0] prdata;
  logic pready;

  max_xor_binary_trie_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .number(number),
    .out_valid(out_valid), .out_stall(out_stall),
    .best_xor(best_xor), .running_max(running_max), .full_res(full_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trie mirror: child links, allocation counters, peak XOR and the register
  logic [mxt_pkg::NODE_W-1:0] trie_zero [mxt_pkg::NODE_DEPTH];
  logic [mxt_pkg::NODE_W-1:0] trie_one [mxt_pkg::NODE_DEPTH];
  int trie_nodes = 1;
  int trie_items = 0;
  logic [mxt_pkg::VALUE_BITS-1:0] xor_peak = '0;
  logic [mxt_pkg::BC_W-1:0] bit_count_reg = mxt_pkg::BC_W'(mxt_pkg::BC_RST);

  mxt_pkg::res_t pending_results [$];
  logic [15:0] recent_numbers [8];
  logic row_typed = 1'b0;
  mxt_pkg::res_t row_want = '0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int idle_cycles = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    for (int i = 0; i < mxt_pkg::NODE_DEPTH; i++) begin
      trie_zero[i] = '0;
      trie_one[i] = '0;
    end
    foreach (recent_numbers[i]) recent_numbers[i] = '0;
  end

  function automatic int eff_bits(input logic [mxt_pkg::BC_W-1:0] v);
    if (v < 1) return 1;
    if (v > mxt_pkg::VALUE_BITS) return mxt_pkg::VALUE_BITS;
    return int'(v);
  endfunction

  function automatic int child_at(input int node, input logic b);
    return b ? int'(trie_one[node]) : int'(trie_zero[node]);
  endfunction

  // Insert the number if room is left, then walk for the largest XOR
  function automatic mxt_pkg::res_t predict_max_xor(input logic [15:0] num);
    int eb;
    int node;
    int c;
    int missing;
    logic b;
    logic stop;
    logic [mxt_pkg::VALUE_BITS-1:0] x;
    mxt_pkg::res_t r;
    eb = eff_bits(bit_count_reg);
    node = 0;
    missing = 0;
    for (int lvl = 0; lvl < eb; lvl++) begin
      b = num[eb-1-lvl];
      c = (missing == 0) ? child_at(node, b) : 0;
      if (c == 0) missing++;
      else node = c;
    end
    r.full = (trie_items >= mxt_pkg::CAPACITY) ||
             (trie_nodes + missing > mxt_pkg::NODE_DEPTH);
    if (!r.full) begin
      node = 0;
      for (int lvl = 0; lvl < eb; lvl++) begin
        b = num[eb-1-lvl];
        c = child_at(node, b);
        if (c == 0) begin
          c = trie_nodes;
          trie_nodes++;
          trie_zero[c] = '0;
          trie_one[c] = '0;
          if (b) trie_one[node] = mxt_pkg::NODE_W'(c);
          else trie_zero[node] = mxt_pkg::NODE_W'(c);
        end
        node = c;
      end
      trie_items++;
    end
    // Prefer the opposite branch; stop where a node has no child at all
    x = '0;
    node = 0;
    stop = 1'b0;
    for (int lvl = 0; lvl < eb && !stop; lvl++) begin
      b = num[eb-1-lvl];
      c = child_at(node, !b);
      if (c != 0) begin
        x[eb-1-lvl] = 1'b1;
        node = c;
      end else begin
        c = child_at(node, b);
        if (c == 0) stop = 1'b1;
        else node = c;
      end
    end
    if (x > xor_peak) xor_peak = x;
    r.best_xor = x;
    r.running_max = xor_peak;
    return r;
  endfunction

  // Random numbers: often near earlier numbers so the trie gets deep and shared
  function automatic logic [15:0] pick_number();
    int eb;
    logic [15:0] base;
    eb = eff_bits(bit_count_reg);
    base = recent_numbers[$urandom_range(0, 7)];
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom());
      4, 5: return base ^ (16'h1 << $urandom_range(0, 15));
      6: return base;
      7: return ~base;
      8: return 16'($urandom_range(0, (1 << eb) - 1));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Sample both channels away from the driving edge
  always @(negedge clk) begin
    in_fire = in_valid && !in_stall && !rst;
    out_fire = out_valid && !out_stall && !rst;
    if (in_fire) begin
      mxt_pkg::res_t r;
      r = predict_max_xor(number);
      if (row_typed) r = row_want;
      pending_results.push_back(r);
    end
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: best_xor %0h", best_xor);
        fail_count++;
      end else begin
        mxt_pkg::res_t e;
        e = pending_results.pop_front();
        if (best_xor !== e.best_xor) begin
          $error("best_xor: expected %0h, got %0h", e.best_xor, best_xor);
          fail_count++;
        end
        if (running_max !== e.running_max) begin
          $error("running_max: expected %0h, got %0h", e.running_max, running_max);
          fail_count++;
        end
        if (full_res !== e.full) begin
          $error("full_res: expected %0b, got %0b", e.full, full_res);
          fail_count++;
        end
      end
    end
    // Count cycles with no progress on either channel
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("max_xor_binary_trie_core verification failed");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_number(input logic [15:0] n, input logic typed,
                             input mxt_pkg::res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    row_typed = typed;
    row_want = want;
    in_valid <= 1'b1;
    number <= n;
    do @(posedge clk); while (!in_fire);
  endtask

  // Hold off input until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write bit_count, then read it back
  task automatic write_bit_count(input logic [mxt_pkg::BC_W-1:0] v);
    logic [mxt_pkg::DATA_W-1:0] got;
    logic [mxt_pkg::DATA_W-1:0] want_rd;
    want_rd = '0;
    want_rd[mxt_pkg::BC_W-1:0] = v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BIT_COUNT_ADDR;
    pwdata <= ($urandom() & ~32'h1F) | mxt_pkg::DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    bit_count_reg = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want_rd) begin
      $error("bit_count: expected %0h, got %0h", want_rd, got);
      fail_count++;
    end
  endtask

  // Directed items: fixed results only where the trie is trivially known
  stim_row_t dir_rows [20] = '{
    {5'd16, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0},
    {5'd16, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0},
    {5'd16, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0},
    {5'd16, 16'h8000, 1'b0, 33'h0},
    {5'd16, 16'h7FFF, 1'b0, 33'h0},
    {5'd16, 16'h0001, 1'b0, 33'h0},
    {5'd16, 16'h0100, 1'b0, 33'h0},
    {5'd16, 16'hAAAA, 1'b0, 33'h0},
    {5'd16, 16'h5555, 1'b0, 33'h0},
    {5'd16, 16'h1234, 1'b0, 33'h0},
    {5'd16, 16'h8001, 1'b0, 33'h0},
    {5'd16, 16'h00FF, 1'b0, 33'h0},
    // bit_count below range: one bit used
    {5'd0,  16'h0001, 1'b0, 33'h0},
    {5'd0,  16'h0000, 1'b0, 33'h0},
    // bit_count above range: sixteen bits used
    {5'd31, 16'hFF00, 1'b0, 33'h0},
    // short path laid down, then a full-width walk that runs off its end
    {5'd4,  16'h0003, 1'b0, 33'h0},
    {5'd16, 16'hC000, 1'b0, 33'h0},
    {5'd17, 16'hEDCB, 1'b0, 33'h0},
    {5'd1,  16'hFFFE, 1'b0, 33'h0},
    {5'd16, 16'h0000, 1'b0, 33'h0}
  };

  logic [mxt_pkg::BC_W-1:0] phase_bc [9] =
    '{5'd16, 5'd8, 5'd1, 5'd0, 5'd31, 5'd12, 5'd3, 5'd20, 5'd16};

  initial begin
    logic [15:0] n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 69;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != bit_count_reg) begin
        drain_results();
        write_bit_count(dir_rows[i].cfg);
      end
      send_number(dir_rows[i].num, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own bit_count
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 36;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      write_bit_count(phase_bc[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        n = pick_number();
        send_number(n, 1'b0, '0);
        recent_numbers[$urandom_range(0, 7)] = n;
      end
    end

    drain_results();
    repeat (48) @(posedge clk);
    if (fail_count == 0) begin
      $display("max_xor_binary_trie_core verification clean");
    end else begin
      $display("max_xor_binary_trie_core verification failed");
    end
    $finish;
  end

endmodule
